// ----- hw/rtl/dltq_pkg.sv -----
// ----------------------------------------------------------------------------
// dltq_pkg: shared constants and types of the delta-list timer queue.
// Holds the sizes, the opcode and status codes and the result word type.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam int DELTA_W = 32;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_START_ONE = 2'd1;
    localparam logic [1:0] OP_START_REP = 2'd2;
    localparam logic [1:0] OP_STOP = 2'd3;

    localparam logic [1:0] ST_OFF = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_ACTIVE = 2'd2;

    typedef struct packed {
        logic [3:0] fired_slot;
        logic       last_fired;
    } t_result;

endpackage

// ----- hw/rtl/dltq_if.sv -----
// ----------------------------------------------------------------------------
// dltq_cmd_if / dltq_res_if: valid-ready channels of the timer queue.
// One word moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface dltq_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [3:0]  timer_slot;
    logic [31:0] delay_ms;
    modport source (output valid, opcode, timer_slot, delay_ms, input ready);
    modport sink (input valid, opcode, timer_slot, delay_ms, output ready);
endinterface

interface dltq_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] fired_slot;
    logic       last_fired;
    modport source (output valid, fired_slot, last_fired, input ready);
    modport sink (input valid, fired_slot, last_fired, output ready);
endinterface

// ----- hw/rtl/dltq_out_buf.sv -----
// ----------------------------------------------------------------------------
// dltq_out_buf: result word FIFO between the sequencer and the output port.
// Holds one tick's worth of expiry reports so the walk never stalls.
// ----------------------------------------------------------------------------
module dltq_out_buf #(
    parameter int DEPTH = dltq_pkg::MAX_RESULTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dltq_pkg::t_result   i_word,
    output logic                o_empty,
    dltq_res_if.source          res
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dltq_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          pop;

    assign pop = res.valid && res.ready;
    assign res.valid = (r_cnt != '0);
    assign res.fired_slot = r_mem[r_rp].fired_slot;
    assign res.last_fired = r_mem[r_rp].last_fired;
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_word;
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(pop);
        end
    end
endmodule

// ----- hw/rtl/delta_list_timer_queue_top.sv -----
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top: millisecond timer queue on a delta-sorted list.
// A small sequencer walks the slot lists with one shared 32-bit adder/compare.
// ----------------------------------------------------------------------------
// Each command word is handled by a sequencer that visits one list entry per
// cycle through a single shared 32-bit subtract/compare unit. A start or stop
// first unlinks the slot, searching the pending list when the slot is pending
// and not its head, and a start with a nonzero delay then puts the slot at
// the head of the pending list. A tick removes each expired head and walks
// the active list to reinsert each repeating slot and each pending slot.
// Expiry reports go into a result FIFO of MAX_RESULTS words; a new command
// word is taken only when the sequencer is idle and the FIFO has drained, so
// every result of a tick has been delivered before the next word is taken.
// Further expiries beyond MAX_RESULTS in one tick take effect without being
// reported, and last_fired marks the final reported word.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dltq_cmd_if.sink   i_cmd,
    dltq_res_if.source o_res
);
    // The slot count is tied to the 4-bit slot fields of both channels.
    localparam int TIMER_SLOTS = dltq_pkg::TIMER_SLOTS_DEF;
    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int LW = $clog2(TIMER_SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(TIMER_SLOTS);
    localparam int RCW = $clog2(dltq_pkg::MAX_RESULTS + 1);
    localparam int GW = $clog2(2 * TIMER_SLOTS + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_STOP = 4'd1;
    localparam logic [3:0] S_PSRCH = 4'd2;
    localparam logic [3:0] S_ARM = 4'd3;
    localparam logic [3:0] S_TICK = 4'd4;
    localparam logic [3:0] S_INS = 4'd5;
    localparam logic [3:0] S_WALK = 4'd6;
    localparam logic [3:0] S_PEND = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;

    logic [31:0]   r_delta [TIMER_SLOTS];
    logic [31:0]   r_reload [TIMER_SLOTS];
    logic [1:0]    r_stat [TIMER_SLOTS];
    logic [LW-1:0] r_next [TIMER_SLOTS];
    logic [LW-1:0] r_prev [TIMER_SLOTS];
    logic [LW-1:0] r_ahead, r_phead;

    logic [3:0]    r_state;
    logic [1:0]    r_op;
    logic [SW-1:0] r_slot;
    logic [31:0]   r_delay;
    logic [SW-1:0] r_s;      // slot being inserted
    logic [31:0]   r_d;      // running delta of the insertion
    logic [LW-1:0] r_t;      // walk cursor
    logic [LW-1:0] r_w;      // pending cursor
    logic          r_ins_pend; // insertion belongs to the pending merge
    logic [GW-1:0] r_guard;
    logic [RCW-1:0] r_cnt;
    logic          r_have;   // a word is held back for last_fired
    logic [3:0]    r_hold;

    logic          push;
    dltq_pkg::t_result word;
    logic          fifo_empty;

    // Shared arithmetic unit: one subtract and one compare.
    logic [31:0] alu_a, alu_b, alu_diff;
    logic        alu_lt;
    assign alu_diff = alu_a - alu_b;
    assign alu_lt = alu_a < alu_b;

    assign i_cmd.ready = (r_state == S_IDLE) && fifo_empty && !r_have;

    dltq_out_buf #(.DEPTH(dltq_pkg::MAX_RESULTS)) u_buf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_word(word),
        .o_empty(fifo_empty), .res(o_res)
    );

    logic [SW-1:0] ti, tn, hs, ws;
    assign ti = r_t[SW-1:0];
    assign hs = r_ahead[SW-1:0];
    assign ws = r_w[SW-1:0];
    assign tn = r_next[ti][SW-1:0];

    always_comb begin
        alu_a = r_d;
        alu_b = r_delta[hs];
        unique case (r_state)
            S_WALK: begin
                alu_a = r_d - r_delta[ti];
                alu_b = r_delta[tn];
            end
            S_TICK: begin
                alu_a = 32'd0;
                alu_b = r_delta[hs];
            end
            S_STOP: begin
                alu_a = r_delta[r_next[r_slot][SW-1:0]];
                alu_b = ~r_delta[r_slot] + 32'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        push <= 1'b0;
        if (!i_rst_n) begin
            for (int i = 0; i < TIMER_SLOTS; i++) begin
                r_delta[i] <= '0;
                r_reload[i] <= '0;
                r_stat[i] <= dltq_pkg::ST_OFF;
                r_next[i] <= NIL;
                r_prev[i] <= NIL;
            end
            r_ahead <= NIL;
            r_phead <= NIL;
            r_state <= S_IDLE;
            r_have <= 1'b0;
            r_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_cmd.valid && i_cmd.ready) begin
                    r_op <= i_cmd.opcode;
                    r_delay <= i_cmd.delay_ms;
                    r_slot <= SW'(i_cmd.timer_slot);
                    r_cnt <= '0;
                    r_guard <= '0;
                    if (i_cmd.opcode == dltq_pkg::OP_TICK) r_state <= S_TICK;
                    else if (32'(i_cmd.timer_slot) >= 32'(TIMER_SLOTS)) r_state <= S_IDLE;
                    else r_state <= S_STOP;
                end
                S_STOP: begin
                    r_state <= S_ARM;
                    if (r_stat[r_slot] == dltq_pkg::ST_ACTIVE) begin
                        if (r_next[r_slot] != NIL) begin
                            r_prev[r_next[r_slot][SW-1:0]] <= r_prev[r_slot];
                            r_delta[r_next[r_slot][SW-1:0]] <= alu_diff;
                        end
                        if (r_prev[r_slot] != NIL)
                            r_next[r_prev[r_slot][SW-1:0]] <= r_next[r_slot];
                        else r_ahead <= r_next[r_slot];
                        r_stat[r_slot] <= dltq_pkg::ST_OFF;
                    end else if (r_stat[r_slot] == dltq_pkg::ST_PENDING) begin
                        r_stat[r_slot] <= dltq_pkg::ST_OFF;
                        if (r_phead == LW'(r_slot)) r_phead <= r_next[r_slot];
                        else begin
                            r_t <= r_phead;
                            r_state <= S_PSRCH;
                        end
                    end
                end
                S_PSRCH: begin
                    if (r_t == NIL || r_guard == GW'(TIMER_SLOTS)) r_state <= S_ARM;
                    else if (r_next[ti] == LW'(r_slot)) begin
                        r_next[ti] <= r_next[r_slot];
                        r_state <= S_ARM;
                    end else begin
                        r_t <= r_next[ti];
                        r_guard <= r_guard + 1'b1;
                    end
                end
                S_ARM: begin
                    r_state <= S_IDLE;
                    if (r_op != dltq_pkg::OP_STOP && r_delay != 32'd0) begin
                        r_delta[r_slot] <= (r_delay > 32'd2) ? r_delay - 32'd2 : 32'd0;
                        r_reload[r_slot] <= (r_op == dltq_pkg::OP_START_REP) ? r_delay : 32'd0;
                        r_prev[r_slot] <= NIL;
                        r_next[r_slot] <= r_phead;
                        r_phead <= LW'(r_slot);
                        r_stat[r_slot] <= dltq_pkg::ST_PENDING;
                    end
                end
                S_TICK: begin
                    if (r_ahead == NIL || r_guard == GW'(2 * TIMER_SLOTS)) begin
                        r_w <= r_phead;
                        r_phead <= NIL;
                        r_guard <= '0;
                        r_state <= S_PEND;
                    end else if (alu_lt) begin
                        r_delta[hs] <= r_delta[hs] - 32'd1;
                        r_w <= r_phead;
                        r_phead <= NIL;
                        r_guard <= '0;
                        r_state <= S_PEND;
                    end else begin
                        r_guard <= r_guard + 1'b1;
                        if (r_next[hs] != NIL) r_prev[r_next[hs][SW-1:0]] <= NIL;
                        r_ahead <= r_next[hs];
                        r_stat[hs] <= dltq_pkg::ST_OFF;
                        if (32'(r_cnt) < 32'(dltq_pkg::MAX_RESULTS)) begin
                            if (r_have) begin
                                push <= 1'b1;
                                word <= '{fired_slot: r_hold, last_fired: 1'b0};
                            end
                            r_hold <= 4'(hs);
                            r_have <= 1'b1;
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (r_reload[hs] != 32'd0) begin
                            r_s <= hs;
                            r_d <= r_reload[hs];
                            r_ins_pend <= 1'b0;
                            r_state <= S_INS;
                        end
                    end
                end
                S_PEND: begin
                    if (r_have) begin
                        push <= 1'b1;
                        word <= '{fired_slot: r_hold, last_fired: 1'b1};
                        r_have <= 1'b0;
                    end
                    if (r_w == NIL || r_guard == GW'(TIMER_SLOTS)) r_state <= S_DRAIN;
                    else begin
                        r_guard <= r_guard + 1'b1;
                        r_s <= ws;
                        r_d <= r_delta[ws];
                        r_w <= r_next[ws];
                        r_ins_pend <= 1'b1;
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    // Head of the insertion: empty list or in front of head.
                    if (r_ahead == NIL) begin
                        r_next[r_s] <= NIL;
                        r_prev[r_s] <= NIL;
                        r_ahead <= LW'(r_s);
                        r_delta[r_s] <= r_d;
                        r_stat[r_s] <= dltq_pkg::ST_ACTIVE;
                        r_state <= r_ins_pend ? S_PEND : S_TICK;
                    end else if (alu_lt) begin
                        r_next[r_s] <= r_ahead;
                        r_prev[r_s] <= NIL;
                        r_prev[hs] <= LW'(r_s);
                        r_delta[hs] <= r_delta[hs] - r_d;
                        r_ahead <= LW'(r_s);
                        r_delta[r_s] <= r_d;
                        r_stat[r_s] <= dltq_pkg::ST_ACTIVE;
                        r_state <= r_ins_pend ? S_PEND : S_TICK;
                    end else begin
                        r_t <= r_ahead;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_next[ti] == NIL) begin
                        r_next[r_s] <= NIL;
                        r_prev[r_s] <= r_t;
                        r_next[ti] <= LW'(r_s);
                        r_delta[r_s] <= r_d - r_delta[ti];
                        r_stat[r_s] <= dltq_pkg::ST_ACTIVE;
                        r_state <= r_ins_pend ? S_PEND : S_TICK;
                    end else if (alu_lt) begin
                        r_next[r_s] <= r_next[ti];
                        r_prev[r_s] <= r_t;
                        r_prev[tn] <= LW'(r_s);
                        r_next[ti] <= LW'(r_s);
                        r_delta[tn] <= r_delta[tn] - alu_a;
                        r_delta[r_s] <= alu_a;
                        r_stat[r_s] <= dltq_pkg::ST_ACTIVE;
                        r_state <= r_ins_pend ? S_PEND : S_TICK;
                    end else begin
                        r_d <= alu_a;
                        r_t <= r_next[ti];
                    end
                end
                S_DRAIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- dv/dltq_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dltq_tb_pkg: expected-behavior model of the delta-list timer queue.
// Keeps its own copy of the slot lists and computes the expiries of a tick.
// ----------------------------------------------------------------------------
package dltq_tb_pkg;
    import dltq_pkg::*;

    localparam int NSLOT = TIMER_SLOTS_DEF;
    localparam logic [4:0] NIL = 5'(NSLOT);

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  timer_slot;
        logic [31:0] delay_ms;
    } t_cmd_word;

    class timer_list_model;
        logic [31:0] delta[NSLOT];
        logic [31:0] reload[NSLOT];
        logic [1:0]  status[NSLOT];
        logic [4:0]  nxt[NSLOT];
        logic [4:0]  prv[NSLOT];
        logic [4:0]  act_head;
        logic [4:0]  pend_head;

        function new();
            clear();
        endfunction

        function void clear();
            for (int i = 0; i < NSLOT; i++) begin
                delta[i] = '0;
                reload[i] = '0;
                status[i] = ST_OFF;
                nxt[i] = NIL;
                prv[i] = NIL;
            end
            act_head = NIL;
            pend_head = NIL;
        endfunction

        // Place a slot on the active list; equal deltas go behind earlier ones.
        function void link_active(int s);
            logic [31:0] d;
            int t, p, cnt;
            d = delta[s];
            if (act_head == NIL) begin
                nxt[s] = NIL;
                prv[s] = NIL;
                act_head = 5'(s);
            end else if (d < delta[act_head]) begin
                nxt[s] = act_head;
                prv[s] = NIL;
                prv[act_head] = 5'(s);
                delta[act_head] -= d;
                act_head = 5'(s);
            end else begin
                t = act_head;
                cnt = 0;
                while (nxt[t] != NIL && cnt < NSLOT) begin
                    cnt++;
                    d -= delta[t];
                    t = nxt[t];
                    if (d < delta[t]) begin
                        p = prv[t];
                        nxt[s] = 5'(t);
                        prv[s] = 5'(p);
                        prv[t] = 5'(s);
                        if (p != NIL) nxt[p] = 5'(s);
                        delta[t] -= d;
                        delta[s] = d;
                        status[s] = ST_ACTIVE;
                        return;
                    end
                end
                d -= delta[t];
                nxt[s] = NIL;
                prv[s] = 5'(t);
                nxt[t] = 5'(s);
            end
            delta[s] = d;
            status[s] = ST_ACTIVE;
        endfunction

        function void unlink(int s);
            int n, p, t, cnt;
            if (status[s] == ST_ACTIVE) begin
                n = nxt[s];
                p = prv[s];
                if (n != NIL) begin
                    prv[n] = 5'(p);
                    delta[n] += delta[s];
                end
                if (p != NIL) nxt[p] = 5'(n);
                else act_head = 5'(n);
                status[s] = ST_OFF;
            end else if (status[s] == ST_PENDING) begin
                if (pend_head == s) begin
                    pend_head = nxt[s];
                end else begin
                    t = pend_head;
                    cnt = 0;
                    while (t != NIL && cnt < NSLOT) begin
                        cnt++;
                        if (nxt[t] == s) begin
                            nxt[t] = nxt[s];
                            break;
                        end
                        t = nxt[t];
                    end
                end
                status[s] = ST_OFF;
            end
        endfunction

        // Apply one command word and append its expiries to the queue.
        function void apply(t_cmd_word c, ref t_result fired_q[$]);
            int t, n, w, cnt, nres;
            t_result r;
            nres = 0;
            if (c.opcode == OP_TICK) begin
                t = act_head;
                cnt = 0;
                while (t != NIL && cnt < 2 * NSLOT) begin
                    cnt++;
                    if (delta[t] > 0) begin
                        delta[t]--;
                        break;
                    end
                    n = nxt[t];
                    if (n != NIL) prv[n] = NIL;
                    act_head = 5'(n);
                    status[t] = ST_OFF;
                    if (nres < MAX_RESULTS) begin
                        r.fired_slot = 4'(t);
                        r.last_fired = 1'b0;
                        fired_q.push_back(r);
                        nres++;
                    end
                    if (reload[t] != 0) begin
                        delta[t] = reload[t];
                        link_active(t);
                    end
                    t = act_head;
                end
                if (nres > 0) fired_q[$].last_fired = 1'b1;
                w = pend_head;
                pend_head = NIL;
                cnt = 0;
                while (w != NIL && cnt < NSLOT) begin
                    n = nxt[w];
                    cnt++;
                    link_active(w);
                    w = n;
                end
                return;
            end
            if (c.timer_slot >= NSLOT) return;
            unlink(c.timer_slot);
            if (c.opcode == OP_STOP || c.delay_ms == 0) return;
            delta[c.timer_slot] = (c.delay_ms > 2) ? c.delay_ms - 2 : 32'd0;
            reload[c.timer_slot] = (c.opcode == OP_START_REP) ? c.delay_ms : 32'd0;
            prv[c.timer_slot] = NIL;
            nxt[c.timer_slot] = pend_head;
            pend_head = 5'(c.timer_slot);
            status[c.timer_slot] = ST_PENDING;
        endfunction
    endclass
endpackage

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the delta-list timer queue.
// Directed and random start/stop/tick words go in with random gaps; every
// expiry word out is checked against a software copy of the slot lists.
// ----------------------------------------------------------------------------
module testbench;
    import dltq_pkg::*;
    import dltq_tb_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    dltq_cmd_if cmd_bus ();
    dltq_res_if res_bus ();

    delta_list_timer_queue_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus.sink),
        .o_res   (res_bus.source)
    );

    // Words waiting to be sent, and expiries still owed by the block.
    t_cmd_word cmd_q[$];
    t_result   fired_q[$];
    timer_list_model timers;

    int  errors;
    bit  stim_done;
    int  send_wait;
    int  recv_wait;
    int  hold_off;
    bit  hold_armed;
    int  quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus. The directed part covers every opcode, the field extremes,
    // zero delays (which leave the slot off), tiny delays (which clamp to a
    // delta of zero), stops of idle slots, stops of pending and active slots,
    // and a tick with sixteen simultaneous expiries that fill the report cap and
    // exercise last_fired. The random part is mostly starts with short
    // delays and ticks, so that lists stay populated and expiries keep coming.
    // ------------------------------------------------------------------------
    function automatic t_cmd_word mk(logic [1:0] op, int s, logic [31:0] d);
        t_cmd_word c;
        c.opcode = op;
        c.timer_slot = 4'(s);
        c.delay_ms = d;
        return c;
    endfunction

    initial begin
        t_cmd_word c;
        int pick;
        errors = 0;
        stim_done = 1'b0;
        timers = new();

        cmd_q.push_back(mk(OP_TICK, 15, 32'hFFFF_FFFF));
        cmd_q.push_back(mk(OP_STOP, 0, 32'h0));
        cmd_q.push_back(mk(OP_START_ONE, 15, 32'hFFFF_FFFF));
        cmd_q.push_back(mk(OP_START_REP, 3, 32'd1));
        cmd_q.push_back(mk(OP_START_ONE, 4, 32'd0));
        cmd_q.push_back(mk(OP_START_ONE, 5, 32'd2));
        cmd_q.push_back(mk(OP_START_REP, 6, 32'd3));
        cmd_q.push_back(mk(OP_STOP, 5, 32'h0));
        cmd_q.push_back(mk(OP_TICK, 0, 32'h0));
        cmd_q.push_back(mk(OP_TICK, 0, 32'h0));
        cmd_q.push_back(mk(OP_TICK, 0, 32'h0));
        cmd_q.push_back(mk(OP_STOP, 15, 32'h0));
        cmd_q.push_back(mk(OP_STOP, 6, 32'hAAAA_5555));
        cmd_q.push_back(mk(OP_STOP, 3, 32'h0));
        // Sixteen one-shots of equal delay expire on the same tick.
        for (int s = 0; s < 16; s++) cmd_q.push_back(mk(OP_START_ONE, s, 32'd1));
        cmd_q.push_back(mk(OP_TICK, 0, 32'h0));
        cmd_q.push_back(mk(OP_TICK, 0, 32'h0));

        for (int i = 0; i < 80; i++) begin
            pick = $urandom_range(0, 9);
            c.opcode = 2'($urandom_range(0, 3));
            c.timer_slot = 4'($urandom);
            c.delay_ms = 32'($urandom_range(0, 6));
            if (pick < 4) c.opcode = OP_TICK;
            else if (pick < 7) c.opcode = ($urandom_range(0, 1)) ? OP_START_REP : OP_START_ONE;
            else if (pick == 9) c.delay_ms = $urandom;
            cmd_q.push_back(c);
        end
        stim_done = 1'b1;
    end

    // Driver: presents one word at a time after a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.opcode <= OP_TICK;
            cmd_bus.timer_slot <= '0;
            cmd_bus.delay_ms <= '0;
            send_wait <= 0;
        end else if (cmd_bus.valid && !cmd_bus.ready) begin
            // Hold the offered word until it is taken.
        end else if (send_wait > 0) begin
            cmd_bus.valid <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (cmd_q.size() > 0) begin
            // The expected expiries are computed once the word is accepted.
            if (cmd_bus.valid) begin
                timers.apply({cmd_bus.opcode, cmd_bus.timer_slot, cmd_bus.delay_ms},
                             fired_q);
            end
            cmd_bus.valid <= 1'b1;
            {cmd_bus.opcode, cmd_bus.timer_slot, cmd_bus.delay_ms} <= cmd_q.pop_front();
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        end else begin
            if (cmd_bus.valid) begin
                timers.apply({cmd_bus.opcode, cmd_bus.timer_slot, cmd_bus.delay_ms},
                             fired_q);
            end
            cmd_bus.valid <= 1'b0;
        end
    end

    // Words accepted while the driver holds a gap must be modeled too.
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready && send_wait > 0) begin
            timers.apply({cmd_bus.opcode, cmd_bus.timer_slot, cmd_bus.delay_ms}, fired_q);
        end
    end

    // Receiver: random ready gaps, plus one long hold-off early in the run
    // so the result FIFO fills and the command side backs up.
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            recv_wait <= 0;
            hold_off <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && fired_q.size() >= 8) begin
            hold_armed <= 1'b0;
            hold_off <= 300;
            res_bus.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res_bus.ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            res_bus.ready <= 1'b0;
        end else if (res_bus.valid && res_bus.ready) begin
            // Draw the wait before the next word right after a word is taken.
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
            recv_wait <= gap;
            res_bus.ready <= (gap == 0);
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    // Monitor: compare each accepted expiry word with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (fired_q.size() == 0) begin
                $display("%0t: unexpected expiry slot=%0d last=%0b", $realtime,
                         res_bus.fired_slot, res_bus.last_fired);
                errors++;
            end else begin
                want = fired_q.pop_front();
                if (res_bus.fired_slot !== want.fired_slot) begin
                    $display("%0t: fired_slot expected %0d actual %0d", $realtime,
                             want.fired_slot, res_bus.fired_slot);
                    errors++;
                end
                if (res_bus.last_fired !== want.last_fired) begin
                    $display("%0t: last_fired expected %0b actual %0b", $realtime,
                             want.last_fired, res_bus.last_fired);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles with no accepted word on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && cmd_q.size() == 0 && !cmd_bus.valid && send_wait == 0
                 && fired_q.size() == 0) && quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        if (quiet_cycles < STALL_LIMIT) begin
            // Let any late or surplus word show up before the verdict.
            repeat (2000) @(posedge i_clk);
            if (errors == 0 && fired_q.size() == 0)
                $display("delta_list_timer_queue_top test passed");
            else
                $display("delta_list_timer_queue_top test failed");
        end else begin
            $display("delta_list_timer_queue_top test failed");
        end
        $finish;
    end
endmodule
